// File: rtl/core/tkpq_pkg.sv
// tkpq_pkg: shared types, codes and reset values for the touch key press qualifier
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package tkpq_pkg;

    // decoded key codes
    typedef enum logic [2:0] {
        KEY_NONE  = 3'd0,
        KEY_K1    = 3'd1,
        KEY_K2    = 3'd2,
        KEY_K3    = 3'd3,
        KEY_K4    = 3'd4,
        KEY_COMBO = 3'd5
    } tkpq_key_t;

    // debounce phase codes
    localparam logic [2:0] PH_REST    = 3'd0;
    localparam logic [2:0] PH_SEEN1   = 3'd1;
    localparam logic [2:0] PH_SEEN2   = 3'd2;
    localparam logic [2:0] PH_CONFIRM = 3'd3;
    localparam logic [2:0] PH_COUNT   = 3'd4;
    localparam logic [2:0] PH_CHECK   = 3'd5;

    // hold counter lanes
    localparam int NUM_LANES = 5;
    localparam int LANE_K1    = 0;
    localparam int LANE_K2    = 1;
    localparam int LANE_K3    = 2;
    localparam int LANE_K4    = 3;
    localparam int LANE_COMBO = 4;

    // register indexes and reset values
    localparam logic [1:0] REG_LONG_PRESS   = 2'd0;
    localparam logic [1:0] REG_REPEAT       = 2'd1;
    localparam logic [1:0] REG_COMBO_WINDOW = 2'd2;
    localparam logic [7:0] LONG_PRESS_RESET   = 8'd150;
    localparam logic [7:0] REPEAT_RESET       = 8'd5;
    localparam logic [7:0] COMBO_WINDOW_RESET = 8'd50;

    // raw scan masks
    localparam logic [15:0] MASK_K2    = 16'h0001;
    localparam logic [15:0] MASK_K1    = 16'h0002;
    localparam logic [15:0] MASK_K4    = 16'h0004;
    localparam logic [15:0] MASK_K3    = 16'h0008;
    localparam logic [15:0] MASK_COMBO = 16'h000c;

    typedef struct packed {
        logic [7:0] long_press_ticks;
        logic [7:0] repeat_ticks;
        logic [7:0] combo_window_ticks;
    } tkpq_cfg_t;

    typedef struct packed {
        logic short_k1;
        logic short_k2;
        logic short_k3;
        logic short_k4;
        logic long_k1;
        logic long_k2;
        logic long_k3;
        logic long_k4;
        logic long_combo;
        logic repeating;
    } tkpq_result_t;

    // map a scan mask to a key code
    function automatic tkpq_key_t decode_mask(input logic [15:0] mask);
        tkpq_key_t k;
        case (mask)
            MASK_K2:    k = KEY_K2;
            MASK_K1:    k = KEY_K1;
            MASK_K4:    k = KEY_K4;
            MASK_K3:    k = KEY_K3;
            MASK_COMBO: k = KEY_COMBO;
            default:    k = KEY_NONE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/touch_key_press_qualifier_core.sv
// touch_key_press_qualifier_core: top level with input register, engine and result register
// depends on tkpq_pkg, tkpq_cfg_regs and tkpq_engine
`timescale 1ns / 1ps
`default_nettype none

// Touch key press qualifier. Each input transaction is one scan tick carrying a
// 16-bit touch mask, and each tick yields exactly one result transaction of ten
// event bits (short, long, auto-repeat pulses and the repeating level). The block
// takes one transaction per clock while the result register is free or draining:
// a scan is captured in an input register, the engine evaluates it in one pass
// against the debounce and counter state, and the events land in a result
// register once the scan advances. The engine state updates only when a scan
// advances. A waiting result holds the scan in the input register, which then
// takes no new scan until the result is taken. Thresholds are written over the APB
// port at byte addresses 0, 4 and 8; the user must write them only while no
// transaction is in flight, as the block itself does not enforce this.

module touch_key_press_qualifier_core
    import tkpq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] touch_mask,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             short_k1,
    output logic             short_k2,
    output logic             short_k3,
    output logic             short_k4,
    output logic             long_k1,
    output logic             long_k2,
    output logic             long_k3,
    output logic             long_k4,
    output logic             long_combo,
    output logic             repeating
);

    tkpq_cfg_t    cfg;
    tkpq_result_t eng_result;
    tkpq_result_t res_reg;
    logic [15:0]  mask_reg;
    logic         in_vld_reg;
    logic         out_vld_reg;
    logic         advance;

    tkpq_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input stage moves into the result stage when that slot is free or draining
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    tkpq_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .mask   (mask_reg),
        .cfg    (cfg),
        .result (eng_result)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            mask_reg <= touch_mask;
        if (advance)
            res_reg <= eng_result;
    end

    assign out_valid  = out_vld_reg;
    assign short_k1   = res_reg.short_k1;
    assign short_k2   = res_reg.short_k2;
    assign short_k3   = res_reg.short_k3;
    assign short_k4   = res_reg.short_k4;
    assign long_k1    = res_reg.long_k1;
    assign long_k2    = res_reg.long_k2;
    assign long_k3    = res_reg.long_k3;
    assign long_k4    = res_reg.long_k4;
    assign long_combo = res_reg.long_combo;
    assign repeating  = res_reg.repeating;

endmodule

`default_nettype wire

// File: rtl/core/tkpq_cfg_regs.sv
// tkpq_cfg_regs: apb register file for the three tick thresholds
// depends on tkpq_pkg
`timescale 1ns / 1ps
`default_nettype none

module tkpq_cfg_regs
    import tkpq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output tkpq_cfg_t        cfg
);

    tkpq_cfg_t  cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // register writes on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks   <= LONG_PRESS_RESET;
            cfg_reg.repeat_ticks       <= REPEAT_RESET;
            cfg_reg.combo_window_ticks <= COMBO_WINDOW_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_LONG_PRESS:   cfg_reg.long_press_ticks   <= pwdata[7:0];
                REG_REPEAT:       cfg_reg.repeat_ticks       <= pwdata[7:0];
                REG_COMBO_WINDOW: cfg_reg.combo_window_ticks <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_LONG_PRESS:   prdata = {24'd0, cfg_reg.long_press_ticks};
            REG_REPEAT:       prdata = {24'd0, cfg_reg.repeat_ticks};
            REG_COMBO_WINDOW: prdata = {24'd0, cfg_reg.combo_window_ticks};
            default:          prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/core/tkpq_engine.sv
// tkpq_engine: debounce phase, hold counters and combo window, one scan per step
// depends on tkpq_pkg; the result is combinational and registered by the top level
`timescale 1ns / 1ps
`default_nettype none

module tkpq_engine
    import tkpq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [15:0] mask,
    input  tkpq_cfg_t        cfg,
    output tkpq_result_t     result
);

    logic [2:0]                 phase_reg, phase_next, phase_inc;
    tkpq_key_t                  cand_reg, cand_next;
    logic [NUM_LANES-1:0][7:0]  hold_reg, hold_next;
    logic [NUM_LANES-1:0]       lr_reg, lr_next;
    logic [1:0]                 udl_reg, udl_next;
    logic                       win_act_reg, win_act_next;
    logic [7:0]                 win_cnt_reg, win_cnt_next;
    logic                       rep_reg, rep_next;

    tkpq_key_t                  key;
    logic [NUM_LANES-1:0]       pulse;
    logic [7:0]                 inc;
    logic                       updown;
    logic                       sk1, sk2, sk3, sk4;

    assign key       = decode_mask(mask);
    assign phase_inc = phase_reg + 3'd1;

    // next state and events for one scan
    always_comb
    begin
        phase_next   = phase_inc;
        cand_next    = cand_reg;
        hold_next    = hold_reg;
        lr_next      = lr_reg;
        udl_next     = udl_reg;
        win_act_next = win_act_reg;
        win_cnt_next = win_cnt_reg;
        rep_next     = rep_reg;
        pulse        = '0;
        inc          = 8'd0;
        updown       = 1'b0;
        sk1          = 1'b0;
        sk2          = 1'b0;
        sk3          = 1'b0;
        sk4          = 1'b0;

        case (phase_inc)
            PH_SEEN1, PH_SEEN2:
            begin
                if (key == KEY_NONE)
                    phase_next = PH_REST;
                else
                    cand_next = key;
            end
            PH_CONFIRM:
            begin
                if (cand_reg != key)
                begin
                    cand_next  = KEY_NONE;
                    phase_next = PH_REST;
                end
            end
            PH_COUNT:
            begin
                // only the lane of the held key advances
                for (int i = 0; i < NUM_LANES; i++)
                begin
                    if (key == tkpq_key_t'(3'(i + 1)))
                    begin
                        inc    = hold_reg[i] + 8'd1;
                        updown = (i == LANE_K3) || (i == LANE_K4);
                        if (!lr_reg[i])
                        begin
                            hold_next[i] = inc;
                            if (inc >= cfg.long_press_ticks)
                            begin
                                hold_next[i] = 8'd0;
                                lr_next[i]   = 1'b1;
                                pulse[i]     = 1'b1;
                                if (updown)
                                    udl_next[1'(i - LANE_K3)] = 1'b1;
                            end
                        end
                        else if (updown)
                        begin
                            udl_next[1'(i - LANE_K3)] = 1'b1;
                            hold_next[i] = inc;
                            if (inc >= cfg.repeat_ticks)
                            begin
                                hold_next[i] = 8'd0;
                                pulse[i]     = 1'b1;
                                rep_next     = 1'b1;
                            end
                        end
                    end
                end
                if (key == KEY_COMBO)
                begin
                    win_act_next = 1'b1;
                    win_cnt_next = 8'd0;
                end
            end
            PH_CHECK:
            begin
                if (key == KEY_NONE)
                begin
                    // release: judge short presses, then clear the hold, long, repeat and debounce state
                    sk1 = (hold_reg[LANE_K1] != 8'd0) &&
                          (hold_reg[LANE_K1] < cfg.long_press_ticks);
                    sk2 = (hold_reg[LANE_K2] != 8'd0) &&
                          (hold_reg[LANE_K2] < cfg.long_press_ticks);
                    sk3 = !udl_reg[0] && (hold_reg[LANE_K3] != 8'd0) &&
                          (hold_reg[LANE_K3] < cfg.long_press_ticks);
                    sk4 = !udl_reg[1] && (hold_reg[LANE_K4] != 8'd0) &&
                          (hold_reg[LANE_K4] < cfg.long_press_ticks);
                    hold_next  = '0;
                    lr_next    = '0;
                    udl_next   = '0;
                    rep_next   = 1'b0;
                    phase_next = PH_REST;
                    cand_next  = KEY_NONE;
                end
                else
                begin
                    phase_next = PH_CONFIRM;
                end
            end
            default: ;
        endcase

        // combo window masks up/down short presses
        if (win_act_next)
        begin
            sk3          = 1'b0;
            sk4          = 1'b0;
            win_cnt_next = win_cnt_next + 8'd1;
            if (win_cnt_next >= cfg.combo_window_ticks)
            begin
                win_cnt_next = 8'd0;
                win_act_next = 1'b0;
            end
        end
    end

    // result fields
    always_comb
    begin
        result.short_k1   = sk1;
        result.short_k2   = sk2;
        result.short_k3   = sk3;
        result.short_k4   = sk4;
        result.long_k1    = pulse[LANE_K1];
        result.long_k2    = pulse[LANE_K2];
        result.long_k3    = pulse[LANE_K3];
        result.long_k4    = pulse[LANE_K4];
        result.long_combo = pulse[LANE_COMBO];
        result.repeating  = rep_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_REST;
            cand_reg    <= KEY_NONE;
            hold_reg    <= '0;
            lr_reg      <= '0;
            udl_reg     <= '0;
            win_act_reg <= 1'b0;
            win_cnt_reg <= 8'd0;
            rep_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            cand_reg    <= cand_next;
            hold_reg    <= hold_next;
            lr_reg      <= lr_next;
            udl_reg     <= udl_next;
            win_act_reg <= win_act_next;
            win_cnt_reg <= win_cnt_next;
            rep_reg     <= rep_next;
        end
    end

endmodule

`default_nettype wire
